// ===== rtl/lrs_pkg.sv =====
// Shared types, constants and codes for the letterbox/rotate YUYV to RGB565 scaler.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lrs_pkg;

	// Display and source geometry
	localparam int OUT_W     = 172;
	localparam int OUT_H     = 320;
	localparam int MAX_DIM   = 4096;
	localparam int TOTAL_PIX = OUT_W * OUT_H;

	localparam int CNT_W  = $clog2(TOTAL_PIX);
	localparam int COL_W  = $clog2(OUT_W);
	localparam int ROW_W  = $clog2(OUT_H);
	localparam int FITW_W = $clog2(OUT_H + 1);
	localparam int FITH_W = $clog2(OUT_W + 1);

	// Field widths
	localparam int DIM_W    = 13;
	localparam int FBYTES_W = 26;
	localparam int WIDX_W   = 23;
	localparam int WORD_W   = 32;
	localparam int PIX_W    = 16;

	// Shared divider: numerator covers (row span) * (13-bit dimension)
	localparam int DIV_NUM_W = ROW_W + DIM_W;
	localparam int DIV_DEN_W = DIM_W;

	localparam int QUEUE_DEPTH_DEF = 4;

	// Input kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_REQ   = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	// Result kinds
	localparam logic [1:0] RK_STATUS = 2'd0;
	localparam logic [1:0] RK_FETCH  = 2'd1;
	localparam logic [1:0] RK_PIXEL  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DISABLED = 2'd1;
	localparam logic [1:0] ST_SEQ      = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SRC_STRIDE = 2'd2;
	localparam logic [1:0] REG_FBYTES     = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] macropixel;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [1:0]        status;
		logic [WIDX_W-1:0] word_index;
		logic [PIX_W-1:0]  pixel;
		logic [CNT_W-1:0]  fb_index;
		logic              last;
	} out_item_t;

	typedef enum logic [1:0] {
		CLS_START,
		CLS_REQ,
		CLS_DATA,
		CLS_BAD
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [WORD_W-1:0] word;
	} q_item_t;

	typedef struct packed {
		logic [DIM_W-1:0]    src_width;
		logic [DIM_W-1:0]    src_height;
		logic [DIM_W-1:0]    src_stride;
		logic [FBYTES_W-1:0] frame_bytes;
	} cfg_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_GEO0,
		BK_GEO1,
		BK_GEO2,
		BK_GEO3,
		BK_REQ0,
		BK_REQ1,
		BK_REQ2,
		BK_REQ3,
		BK_DAT0,
		BK_DAT1
	} bk_state_t;

endpackage
`default_nettype wire

// ===== rtl/lrs_front.sv =====
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on lrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrs_front #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  lrs_pkg::in_item_t   in_data,
	output logic                q_valid,
	output lrs_pkg::q_item_t    q_item,
	input  wire                 q_pop
);
	import lrs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	q_item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0]   count_q;
	logic                push;
	logic                pop;
	cls_t                cls;

	// Classify the kind code
	always_comb begin
		unique case (in_data.kind)
			KIND_START: cls = CLS_START;
			KIND_REQ:   cls = CLS_REQ;
			KIND_DATA:  cls = CLS_DATA;
			default:    cls = CLS_BAD;
		endcase
	end

	assign in_stall = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	// Store transfers
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{cls: cls, word: in_data.macropixel};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");
`endif

endmodule
`default_nettype wire

// ===== rtl/lrs_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on lrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrs_div (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire  [lrs_pkg::DIV_NUM_W-1:0]      num,
	input  wire  [lrs_pkg::DIV_DEN_W-1:0]      den,
	output logic                               busy,
	output logic                               done,
	output logic [lrs_pkg::DIV_NUM_W-1:0]      quo
);
	import lrs_pkg::*;

	localparam int STEP_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q, done_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   shifted;
	logic                 fits;

	// Trial subtract of the divisor
	assign shifted = {rem_q[DIV_DEN_W-1:0], quo_q[DIV_NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/lrs_back.sv =====
// Back end: frame geometry, display walk, fetch address and BT.601 color conversion.
// Depends on lrs_pkg; drives the shared divider lrs_div.
`timescale 1ns / 1ps
`default_nettype none
module lrs_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  lrs_pkg::cfg_t                      cfg,
	input  wire                                q_valid,
	input  lrs_pkg::q_item_t                   q_item,
	output logic                               q_pop,
	output logic                               div_start,
	output logic [lrs_pkg::DIV_NUM_W-1:0]      div_num,
	output logic [lrs_pkg::DIV_DEN_W-1:0]      div_den,
	input  wire                                div_busy,
	input  wire                                div_done,
	input  wire  [lrs_pkg::DIV_NUM_W-1:0]      div_quo,
	output logic                               out_valid,
	input  wire                                out_stall,
	output lrs_pkg::out_item_t                 out_data
);
	import lrs_pkg::*;

	localparam int MT_W  = 2 * DIM_W;
	localparam int FSZ_W = FBYTES_W + 2;
	localparam int T_W   = WIDX_W + 1;
	localparam int CV_W  = 20;

	localparam logic signed [CV_W-1:0] K_CY  = CV_W'(298);
	localparam logic signed [CV_W-1:0] K_RV  = CV_W'(409);
	localparam logic signed [CV_W-1:0] K_GU  = CV_W'(100);
	localparam logic signed [CV_W-1:0] K_GV  = CV_W'(208);
	localparam logic signed [CV_W-1:0] K_BU  = CV_W'(516);
	localparam logic signed [CV_W-1:0] K_RND = CV_W'(128);

	bk_state_t state_q, state_nx;

	// Frame state
	logic                enabled_q, awaiting_q, odd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [FITW_W-1:0]   fit_w_q, off_x_q;
	logic [FITH_W-1:0]   fit_h_q, off_y_q;
	logic [DIM_W-1:0]    eff_stride_q;

	// Work registers
	logic [WORD_W-1:0]   word_q;
	logic                cond_q;
	logic [MT_W-1:0]     mt_q;
	logic [MT_W-1:0]     max_q;
	logic [FSZ_W-1:0]    fsz_q;
	logic [DIM_W:0]      sx_q;
	logic [T_W-1:0]      tprod_q;
	logic signed [CV_W-1:0] c_q, rv_q, gu_q, gv_q, bu_q;

	// Output register
	logic                out_valid_q;
	out_item_t           out_q;
	logic                out_free;
	logic                emit;
	out_item_t           emit_item;

	// Combinational helpers
	logic                dims_ok;
	logic                cond_n;
	logic [DIM_W-1:0]    stride_n;
	logic [ROW_W-1:0]    x_n;
	logic                bar_n;
	logic                last_n;
	logic [CNT_W-1:0]    cnt_nx;
	logic [ROW_W-1:0]    row_nx;
	logic [COL_W-1:0]    col_nx;
	logic [DIV_NUM_W-1:0] dim_n;
	logic [FITW_W-1:0]   dw_n;
	logic [FITH_W-1:0]   dh_n;
	logic [DIM_W:0]      sx_n, sy_n;
	logic [T_W-1:0]      t_n;
	logic [MT_W-2:0]     half_n;
	logic [FSZ_W-1:0]    need_n;
	logic                geo_ok;
	logic [7:0]          y_n;
	logic signed [CV_W-1:0] yd_n, u_n, v_n;
	logic signed [CV_W-1:0] r_sum, g_sum, b_sum;
	logic [7:0]          r8, g8, b8;
	logic [PIX_W-1:0]    pix_n;

	function automatic logic [7:0] clamp8(input logic signed [CV_W-1:0] s);
		logic [7:0] res;
		if (s[CV_W-1]) begin
			res = 8'd0;
		end else if (s[CV_W-2:16] != '0) begin
			res = 8'hFF;
		end else begin
			res = s[15:8];
		end
		return res;
	endfunction

	assign out_free = !out_valid_q || !out_stall;

	// Geometry checks and fit selection
	assign dims_ok = (cfg.src_width != '0) && (cfg.src_height != '0) &&
		(cfg.src_width <= DIM_W'(MAX_DIM)) && (cfg.src_height <= DIM_W'(MAX_DIM));
	assign stride_n = ((cfg.src_stride == '0) || cfg.src_stride[0]) ?
		cfg.src_width : cfg.src_stride;
	assign cond_n = (DIV_NUM_W'(OUT_H) * DIV_NUM_W'(cfg.src_height)) <=
		(DIV_NUM_W'(OUT_W) * DIV_NUM_W'(cfg.src_width));
	assign dim_n = div_quo;
	assign dh_n = (dim_n == '0) ? FITH_W'(1) :
		(dim_n > DIV_NUM_W'(OUT_W)) ? FITH_W'(OUT_W) : dim_n[FITH_W-1:0];
	assign dw_n = (dim_n == '0) ? FITW_W'(1) :
		(dim_n > DIV_NUM_W'(OUT_H)) ? FITW_W'(OUT_H) : dim_n[FITW_W-1:0];
	assign half_n = max_q[MT_W-1:1];
	assign need_n = {FSZ_W'(half_n)} * FSZ_W'(4) + FSZ_W'(4);
	assign geo_ok = (half_n[MT_W-2:WIDX_W] == '0) && (need_n <= fsz_q);

	// Display walk
	assign x_n = ROW_W'(OUT_H - 1) - row_q;
	assign bar_n = (FITW_W'(x_n) < off_x_q) ||
		({1'b0, FITW_W'(x_n)} >= ({1'b0, off_x_q} + {1'b0, fit_w_q})) ||
		(FITH_W'(col_q) < off_y_q) ||
		({1'b0, FITH_W'(col_q)} >= ({1'b0, off_y_q} + {1'b0, fit_h_q}));
	assign last_n = (cnt_q == CNT_W'(TOTAL_PIX - 1));
	always_comb begin
		if (last_n) begin
			cnt_nx = '0;
			row_nx = '0;
			col_nx = '0;
		end else if (col_q == COL_W'(OUT_W - 1)) begin
			cnt_nx = cnt_q + 1'b1;
			row_nx = row_q + 1'b1;
			col_nx = '0;
		end else begin
			cnt_nx = cnt_q + 1'b1;
			row_nx = row_q;
			col_nx = col_q + 1'b1;
		end
	end

	// Source coordinate clamp; a zero dimension yields minus one
	assign sx_n = (div_quo >= DIV_NUM_W'(cfg.src_width)) ?
		{1'b0, cfg.src_width} - 1'b1 : (DIM_W + 1)'(div_quo);
	assign sy_n = (div_quo >= DIV_NUM_W'(cfg.src_height)) ?
		{1'b0, cfg.src_height} - 1'b1 : (DIM_W + 1)'(div_quo);
	assign t_n = tprod_q + {{(T_W - DIM_W - 1){sx_q[DIM_W]}}, sx_q};

	// Color conversion operands
	assign y_n  = odd_q ? word_q[23:16] : word_q[7:0];
	assign yd_n = CV_W'(y_n) - CV_W'(16);
	assign u_n  = CV_W'(word_q[15:8]) - CV_W'(128);
	assign v_n  = CV_W'(word_q[31:24]) - CV_W'(128);
	assign r_sum = c_q + rv_q + K_RND;
	assign g_sum = c_q - gu_q - gv_q + K_RND;
	assign b_sum = c_q + bu_q + K_RND;
	assign r8 = clamp8(r_sum);
	assign g8 = clamp8(g_sum);
	assign b8 = clamp8(b_sum);
	assign pix_n = {r8[7:3], g8[7:2], b8[7:3]};

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free) begin
					unique case (q_item.cls)
						CLS_START: state_nx = BK_GEO0;
						CLS_REQ:   state_nx = BK_REQ0;
						CLS_DATA:  state_nx = BK_DAT0;
						default:   state_nx = BK_IDLE;
					endcase
				end
			end
			BK_GEO0: state_nx = dims_ok ? BK_GEO1 : BK_IDLE;
			BK_GEO1: if (div_done) state_nx = BK_GEO2;
			BK_GEO2: state_nx = BK_GEO3;
			BK_GEO3: state_nx = BK_IDLE;
			BK_REQ0: state_nx = (!enabled_q || awaiting_q || bar_n) ? BK_IDLE : BK_REQ1;
			BK_REQ1: if (div_done) state_nx = BK_REQ2;
			BK_REQ2: if (div_done) state_nx = BK_REQ3;
			BK_REQ3: state_nx = BK_IDLE;
			BK_DAT0: state_nx = awaiting_q ? BK_DAT1 : BK_IDLE;
			BK_DAT1: state_nx = BK_IDLE;
			default: state_nx = BK_IDLE;
		endcase
	end

	// Outputs: queue pop, divider start, result
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		emit      = 1'b0;
		emit_item = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_item.cls == CLS_BAD) begin
						emit = 1'b1;
						emit_item.result_kind = RK_STATUS;
						emit_item.status = ST_SEQ;
					end
				end
			end
			BK_GEO0: begin
				if (dims_ok) begin
					div_start = 1'b1;
					div_num = cond_n ?
						DIV_NUM_W'(cfg.src_height) * DIV_NUM_W'(OUT_H) :
						DIV_NUM_W'(cfg.src_width) * DIV_NUM_W'(OUT_W);
					div_den = cond_n ? cfg.src_width : cfg.src_height;
				end else begin
					emit = 1'b1;
					emit_item.result_kind = RK_STATUS;
					emit_item.status = ST_DISABLED;
				end
			end
			BK_GEO3: begin
				emit = 1'b1;
				emit_item.result_kind = RK_STATUS;
				emit_item.status = geo_ok ? ST_OK : ST_DISABLED;
			end
			BK_REQ0: begin
				if (!enabled_q) begin
					emit = 1'b1;
					emit_item.result_kind = RK_STATUS;
					emit_item.status = ST_DISABLED;
				end else if (awaiting_q) begin
					emit = 1'b1;
					emit_item.result_kind = RK_STATUS;
					emit_item.status = ST_SEQ;
				end else if (bar_n) begin
					emit = 1'b1;
					emit_item.result_kind = RK_PIXEL;
					emit_item.fb_index = cnt_q;
					emit_item.last = last_n;
				end else begin
					div_start = 1'b1;
					div_num = DIV_NUM_W'(FITW_W'(x_n) - off_x_q) *
						DIV_NUM_W'(cfg.src_width);
					div_den = DIV_DEN_W'(fit_w_q);
				end
			end
			BK_REQ1: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num = DIV_NUM_W'(FITH_W'(col_q) - off_y_q) *
						DIV_NUM_W'(cfg.src_height);
					div_den = DIV_DEN_W'(fit_h_q);
				end
			end
			BK_REQ3: begin
				emit = 1'b1;
				emit_item.result_kind = RK_FETCH;
				emit_item.word_index = t_n[T_W-1:1];
				emit_item.fb_index = cnt_q;
			end
			BK_DAT0: begin
				if (!awaiting_q) begin
					emit = 1'b1;
					emit_item.result_kind = RK_STATUS;
					emit_item.status = ST_SEQ;
				end
			end
			BK_DAT1: begin
				emit = 1'b1;
				emit_item.result_kind = RK_PIXEL;
				emit_item.pixel = pix_n;
				emit_item.fb_index = cnt_q;
				emit_item.last = last_n;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			enabled_q   <= 1'b0;
			awaiting_q  <= 1'b0;
			odd_q       <= 1'b0;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (q_pop && q_item.cls == CLS_START) begin
						cnt_q      <= '0;
						row_q      <= '0;
						col_q      <= '0;
						awaiting_q <= 1'b0;
						odd_q      <= 1'b0;
					end
				end
				BK_GEO0: if (!dims_ok) enabled_q <= 1'b0;
				BK_GEO3: enabled_q <= geo_ok;
				BK_REQ0: begin
					if (enabled_q && !awaiting_q && bar_n) begin
						cnt_q <= cnt_nx;
						row_q <= row_nx;
						col_q <= col_nx;
					end
				end
				BK_REQ3: begin
					odd_q      <= t_n[0];
					awaiting_q <= 1'b1;
				end
				BK_DAT1: begin
					cnt_q      <= cnt_nx;
					row_q      <= row_nx;
					col_q      <= col_nx;
					awaiting_q <= 1'b0;
				end
				default: begin
					awaiting_q <= awaiting_q;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_item;
		end
		unique case (state_q)
			BK_IDLE: if (q_pop) word_q <= q_item.word;
			BK_GEO0: begin
				cond_q       <= cond_n;
				eff_stride_q <= stride_n;
			end
			BK_GEO1: begin
				if (div_done) begin
					fit_w_q <= cond_q ? FITW_W'(OUT_H) : dw_n;
					fit_h_q <= cond_q ? dh_n : FITH_W'(OUT_W);
					off_x_q <= cond_q ? '0 : (FITW_W'(OUT_H) - dw_n) >> 1;
					off_y_q <= cond_q ? (FITH_W'(OUT_W) - dh_n) >> 1 : '0;
					mt_q    <= MT_W'(cfg.src_height - 1'b1) * MT_W'(eff_stride_q);
				end
			end
			BK_GEO2: begin
				max_q <= mt_q + MT_W'(cfg.src_width - 1'b1);
				fsz_q <= (cfg.frame_bytes != '0) ? FSZ_W'(cfg.frame_bytes) :
					FSZ_W'(eff_stride_q) * FSZ_W'(cfg.src_height) * FSZ_W'(2);
			end
			BK_REQ1: if (div_done) sx_q <= sx_n;
			BK_REQ2: begin
				if (div_done) begin
					tprod_q <= {{(T_W - DIM_W - 1){sy_n[DIM_W]}}, sy_n} *
						T_W'(eff_stride_q);
				end
			end
			BK_DAT0: begin
				c_q  <= K_CY * yd_n;
				rv_q <= K_RV * v_n;
				gu_q <= K_GU * u_n;
				gv_q <= K_GV * v_n;
				bu_q <= K_BU * u_n;
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrites a pending result");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");
	a_status_fb: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind == RK_STATUS) |->
		(out_q.fb_index == '0 && !out_q.last))
		else $error("status result carries a pixel index");
	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TOTAL_PIX - 1))
		else $error("pixel counter out of range");
	a_fetch_awaits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_REQ3) |=> awaiting_q)
		else $error("fetch without awaiting data");
`endif

endmodule
`default_nettype wire

// ===== rtl/letterbox_rotate_yuyv_to_rgb565.sv =====
// Top level of the letterbox/rotate YUYV to RGB565 preview scaler: register port and wiring.
// Depends on lrs_pkg, lrs_front, lrs_div and lrs_back.
//
// Each input item yields exactly one result. The long items are a start item and a request
// that lands on a picture pixel: both wait on the shared one-bit-per-cycle divider (two
// divisions per fetched pixel, one per start), while a bar pixel, a data item and a bad item
// need no division. The back end handles one item at a time and waits while its output
// register holds a stalled result; meanwhile a queue of QUEUE_DEPTH entries (4 by default)
// keeps accepting input until it is full. Configuration is a 32-bit APB-style port with
// registers src_width, src_height, src_stride and frame_bytes at byte addresses 0, 4, 8 and
// 12; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module letterbox_rotate_yuyv_to_rgb565 #(
	parameter int QUEUE_DEPTH = lrs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [3:0]           paddr,
	input  wire  [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  lrs_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output lrs_pkg::out_item_t   out_data
);
	import lrs_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [1:0]           reg_idx;
	logic                 q_valid, q_pop;
	q_item_t              q_item;
	logic                 div_start, div_busy, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic [DIV_DEN_W-1:0] div_den;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width   <= DIM_W'(1920);
			cfg_q.src_height  <= DIM_W'(1080);
			cfg_q.src_stride  <= '0;
			cfg_q.frame_bytes <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SRC_WIDTH:  cfg_q.src_width   <= pwdata[DIM_W-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height  <= pwdata[DIM_W-1:0];
				REG_SRC_STRIDE: cfg_q.src_stride  <= pwdata[DIM_W-1:0];
				REG_FBYTES:     cfg_q.frame_bytes <= pwdata[FBYTES_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			REG_SRC_WIDTH:  prdata = 32'(cfg_q.src_width);
			REG_SRC_HEIGHT: prdata = 32'(cfg_q.src_height);
			REG_SRC_STRIDE: prdata = 32'(cfg_q.src_stride);
			REG_FBYTES:     prdata = 32'(cfg_q.frame_bytes);
			default:        prdata = '0;
		endcase
	end

	lrs_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	lrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	lrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.div_start (div_start),
		.div_num   (div_num),
		.div_den   (div_den),
		.div_busy  (div_busy),
		.div_done  (div_done),
		.div_quo   (div_quo),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
